FILE: rtl/core/qs_pkg.sv
// Shared constants, types and helper functions of the quicksort engine.
package qs_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RANGE_W     = 2 * IDX_W;
  localparam int unsigned LFSR_W      = 16;
  localparam int unsigned DVS_W       = IDX_W + 1;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_RANGE,
    S_MOD_WAIT,
    S_PIV_RD,
    S_PIV_LD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_INC,
    S_SW_RDA,
    S_SW_RDB,
    S_SW_WRA,
    S_SW_WRB,
    S_PUSH_LO,
    S_PUSH_HI,
    S_EM_RD,
    S_EM_LD
  } qs_state_e;

  // Request into the remainder unit.
  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } qs_mod_req_t;

  // Answer from the remainder unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] rem;
  } qs_mod_rsp_t;

  // One step of the 16-bit Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/qs_ram.sv
// Generic single-write, single-read memory with a registered read port.
module qs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/qs_mod.sv
// Restoring remainder unit: one dividend bit per cycle, used for random pivot picks.
module qs_mod
  import qs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qs_mod_req_t req_i,
  output qs_mod_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(LFSR_W);

  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [LFSR_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W-1:0]  trial;

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[LFSR_W-1]};
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = STEP_W'(LFSR_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder always stays below the divisor, so it fits IDX_W bits.
      if (trial >= dvs_q) begin
        rem_d = IDX_W'(trial - dvs_q);
      end else begin
        rem_d = IDX_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: rtl/core/quicksort_engine.sv
// Top level of the quicksort engine: load, in-place sort sequencer and result emission.
//
// Usage: values arrive on the slave stream, one request per value, and are
// stored in order until a request with tlast set. Up to 64 values are kept;
// further ones are dropped and the run reports overflow on tuser. The block
// then sorts the stored set in ascending signed order with a Lomuto
// quicksort driven by a range stack held in memory, and emits the sorted
// values on the master stream, tlast on the final one.
// Loading keeps the slave side ready and stores each accepted value. Sorting
// runs one memory access per cycle over the element memory, which has one
// write and one read port: each partition costs an overhead, a read and
// compare per scanned element and a swap for each element moved left, plus
// a wait on the remainder unit and a swap when a random pivot is chosen.
// An ordered set under last-element pivots sorts far slower than a typical
// set. Emission reads each value, then loads it into the output register.
// The slave side is not ready while sorting or emitting; the final
// result may still wait in the output register while the next set loads.
// If the receiver stalls, the held result stays put and the sequencer waits.
// Reset empties the set, clears the output register, selects last-element
// pivots and seeds the pivot LFSR with 0xACE1. Write the pivot mode only when idle.
module quicksort_engine
  import qs_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: bit 0 selects a random pivot
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // slave stream, tdata: [31:0] element_value; tlast: last_element
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic signed [VALUE_WIDTH-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  // master stream, tdata: [31:0] sorted_value; tlast: last_sorted
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic signed [VALUE_WIDTH-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // tuser: [0] overflow
  output logic [0:0]                    m_axis_tuser
);

  qs_state_e state_q, state_d;
  qs_state_e ret_q, ret_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              drop_q, drop_d;
  logic              mode_q;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]  bnd_q, bnd_d, scan_q, scan_d;
  logic [IDX_W-1:0]  swa_q, swa_d, swb_q, swb_d;
  logic [IDX_W-1:0]  emk_q, emk_d;
  logic signed [VALUE_WIDTH-1:0] pivot_q, pivot_d;
  logic [VALUE_WIDTH-1:0]        va_q, va_d;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ovf_q, out_ovf_d;
  logic                   emit_last;

  // element memory
  logic                   st_we, st_re;
  logic [IDX_W-1:0]       st_waddr, st_raddr;
  logic [VALUE_WIDTH-1:0] st_wdata, st_rdata;
  // range stack memory: {low, high}
  logic                   sk_we, sk_re;
  logic [IDX_W-1:0]       sk_waddr, sk_raddr;
  logic [RANGE_W-1:0]     sk_wdata, sk_rdata;

  qs_mod_req_t mod_req;
  qs_mod_rsp_t mod_rsp;

  logic [IDX_W-1:0] rng_lo, rng_hi;
  logic [DVS_W-1:0] pick_sum;

  qs_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VALUE_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  qs_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(RANGE_W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .re_i   (sk_re),
    .raddr_i(sk_raddr),
    .rdata_o(sk_rdata)
  );

  qs_mod u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  assign rng_lo   = sk_rdata[RANGE_W-1:IDX_W];
  assign rng_hi   = sk_rdata[IDX_W-1:0];
  assign pick_sum = {1'b0, lo_q} + {1'b0, mod_rsp.rem};
  assign emit_last = ({1'b0, emk_q} + CNT_W'(1)) == count_q;

  assign s_axis_tready = (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    count_d = count_q;
    drop_d  = drop_q;
    lfsr_d  = lfsr_q;
    sp_d    = sp_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    bnd_d   = bnd_q;
    scan_d  = scan_q;
    swa_d   = swa_q;
    swb_d   = swb_q;
    emk_d   = emk_q;
    pivot_d = pivot_q;
    va_d    = va_q;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_re    = 1'b0;
    sk_raddr = '0;

    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_next(lfsr_q);
    mod_req.divisor  = {1'b0, rng_hi} - {1'b0, rng_lo} + DVS_W'(1);

    unique case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid) begin
          if (count_q < CNT_W'(CAPACITY)) begin
            st_we    = 1'b1;
            st_waddr = count_q[IDX_W-1:0];
            st_wdata = s_axis_tdata;
            count_d  = count_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        // A set of fewer than two values is already sorted.
        if (count_q >= CNT_W'(2)) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {IDX_W'(0), IDX_W'(count_q - CNT_W'(1))};
          sp_d     = SP_W'(1);
        end else begin
          sp_d = '0;
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          emk_d   = '0;
          state_d = S_EM_RD;
        end else begin
          sk_re    = 1'b1;
          sk_raddr = IDX_W'(sp_q - SP_W'(1));
          sp_d     = sp_q - SP_W'(1);
          state_d  = S_RANGE;
        end
      end
      S_RANGE: begin
        lo_d = rng_lo;
        hi_d = rng_hi;
        if (rng_lo >= rng_hi) begin
          state_d = S_POP;
        end else if (mode_q) begin
          lfsr_d        = lfsr_next(lfsr_q);
          mod_req.start = 1'b1;
          state_d       = S_MOD_WAIT;
        end else begin
          state_d = S_PIV_RD;
        end
      end
      S_MOD_WAIT: begin
        if (mod_rsp.done) begin
          swa_d   = pick_sum[IDX_W-1:0];
          swb_d   = hi_q;
          ret_d   = S_PIV_RD;
          state_d = S_SW_RDA;
        end
      end
      S_PIV_RD: begin
        st_re    = 1'b1;
        st_raddr = hi_q;
        state_d  = S_PIV_LD;
      end
      S_PIV_LD: begin
        pivot_d = st_rdata;
        bnd_d   = lo_q;
        scan_d  = lo_q;
        state_d = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (scan_q == hi_q) begin
          // Scan finished: move the pivot to the boundary.
          swa_d   = bnd_q;
          swb_d   = hi_q;
          ret_d   = S_PUSH_LO;
          state_d = S_SW_RDA;
        end else begin
          st_re    = 1'b1;
          st_raddr = scan_q;
          state_d  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if ($signed(st_rdata) <= pivot_q) begin
          swa_d   = bnd_q;
          swb_d   = scan_q;
          ret_d   = S_SCAN_INC;
          state_d = S_SW_RDA;
        end else begin
          scan_d  = scan_q + IDX_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_INC: begin
        bnd_d   = bnd_q + IDX_W'(1);
        scan_d  = scan_q + IDX_W'(1);
        state_d = S_SCAN_RD;
      end
      S_SW_RDA: begin
        st_re    = 1'b1;
        st_raddr = swa_q;
        state_d  = S_SW_RDB;
      end
      S_SW_RDB: begin
        va_d     = st_rdata;
        st_re    = 1'b1;
        st_raddr = swb_q;
        state_d  = S_SW_WRA;
      end
      S_SW_WRA: begin
        st_we    = 1'b1;
        st_waddr = swa_q;
        st_wdata = st_rdata;
        state_d  = S_SW_WRB;
      end
      S_SW_WRB: begin
        st_we    = 1'b1;
        st_waddr = swb_q;
        st_wdata = va_q;
        state_d  = ret_q;
      end
      S_PUSH_LO: begin
        if (({1'b0, bnd_q} > ({1'b0, lo_q} + DVS_W'(1))) &&
            (sp_q < SP_W'(STACK_DEPTH))) begin
          sk_we    = 1'b1;
          sk_waddr = sp_q[IDX_W-1:0];
          sk_wdata = {lo_q, bnd_q - IDX_W'(1)};
          sp_d     = sp_q + SP_W'(1);
        end
        state_d = S_PUSH_HI;
      end
      S_PUSH_HI: begin
        if ((({1'b0, bnd_q} + DVS_W'(1)) < {1'b0, hi_q}) &&
            (sp_q < SP_W'(STACK_DEPTH))) begin
          sk_we    = 1'b1;
          sk_waddr = sp_q[IDX_W-1:0];
          sk_wdata = {bnd_q + IDX_W'(1), hi_q};
          sp_d     = sp_q + SP_W'(1);
        end
        state_d = S_POP;
      end
      S_EM_RD: begin
        st_re    = 1'b1;
        st_raddr = emk_q;
        state_d  = S_EM_LD;
      end
      S_EM_LD: begin
        // The read data holds until the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = st_rdata;
          out_last_d  = emit_last;
          out_ovf_d   = drop_q;
          if (emit_last) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            emk_d   = emk_q + IDX_W'(1);
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ret_q       <= S_LOAD;
      count_q     <= '0;
      drop_q      <= 1'b0;
      mode_q      <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      bnd_q       <= '0;
      scan_q      <= '0;
      swa_q       <= '0;
      swb_q       <= '0;
      emk_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      lfsr_q      <= lfsr_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      bnd_q       <= bnd_d;
      scan_q      <= scan_d;
      swa_q       <= swa_d;
      swb_q       <= swb_d;
      emk_q       <= emk_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q    <= pivot_d;
    va_q       <= va_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_ovf_q;

  // The range stack never grows past its depth.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("range stack pointer beyond depth");

  // During a scan the boundary trails the scan index, which stays inside the range.
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_RD) |-> (bnd_q <= scan_q && scan_q <= hi_q && lo_q <= bnd_q))
    else $error("partition indices out of order");

  // The remainder unit only finishes while the sequencer waits for it.
  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_MOD_WAIT))
    else $error("remainder result outside of its wait state");

  // The remainder unit only works while the sequencer waits for it.
  a_mod_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.busy |-> (state_q == S_MOD_WAIT))
    else $error("remainder unit busy outside of its wait state");

  // A random pivot always lands inside the current range.
  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD_WAIT && mod_rsp.done) |-> (pick_sum <= {1'b0, hi_q}))
    else $error("random pivot outside of the range");

endmodule
